// ===== rtl/sram_pkg.sv =====
`default_nettype none
package sram_pkg;
	localparam int MAX_RANGES_DEF = 64;
	localparam int ADDR_BITS_DEF = 32;
	localparam int TAG_W = 32;
	localparam int FIELD_W = 32;

	typedef enum logic [1:0] {
		MODE_ALLOC  = 2'd0,
		MODE_FREE   = 2'd1,
		MODE_LOOKUP = 2'd2,
		MODE_BAD    = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_BUSY    = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CMD_HOLD  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_OPEN  = 2'd2,
		CMD_CLOSE = 2'd3
	} cmd_t;

	typedef enum logic {
		PH_IDLE = 1'b0,
		PH_EXEC = 1'b1
	} phase_t;

	localparam logic [0:0] REG_LOW = 1'b0;
	localparam logic [0:0] REG_HIGH = 1'b1;
endpackage
`default_nettype wire

// ===== rtl/sorted_range_allocation_map_unit.sv =====
`default_nettype none
// Flow: a request is taken in IDLE, decided in EXEC and its result registered;
// one item in flight, with no new item taken before EXEC ends and the result is free
// (compare across all cells, then a write or shift of the cell row).
// Reset: entry count zero, bounds to 0 and all ones; table contents are
// not cleared, and slots at or above the count are masked out of the search.
module sorted_range_allocation_map_unit import sram_pkg::*; #(
	parameter int MAX_RANGES = MAX_RANGES_DEF,
	parameter int ADDR_BITS = ADDR_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [0:0]           cfg_index,
	input  wire logic [FIELD_W-1:0]   cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [1:0]           mode,
	input  wire logic [FIELD_W-1:0]   addr,
	input  wire logic [FIELD_W-1:0]   size,
	input  wire logic [TAG_W-1:0]     tag,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [1:0]                status,
	output logic                      found,
	output logic [FIELD_W-1:0]        range_start,
	output logic [FIELD_W-1:0]        range_end,
	output logic [TAG_W-1:0]          range_tag
);
	localparam int AW = ADDR_BITS;
	localparam int N = MAX_RANGES;
	localparam int IW = $clog2(N);
	localparam int CW = $clog2(N + 1);
	localparam int XW = (AW > FIELD_W) ? AW : FIELD_W;

	function automatic logic [AW-1:0] to_aw(input logic [FIELD_W-1:0] v);
		logic [XW-1:0] x;
		x = XW'(v);
		return x[AW-1:0];
	endfunction

	function automatic logic [FIELD_W-1:0] to_fw(input logic [AW-1:0] v);
		logic [XW-1:0] x;
		x = XW'(v);
		return x[FIELD_W-1:0];
	endfunction

	phase_t phase_q, phase_d;
	logic [AW-1:0] low_q, high_q;
	logic [CW-1:0] count_q;
	logic [1:0] mode_q;
	logic [AW-1:0] a_q;
	logic [FIELD_W-1:0] size_q;
	logic [TAG_W-1:0] tag_q;

	logic [N-1:0] ge;
	logic [AW-1:0] c_first [N];
	logic [AW-1:0] c_last [N];
	logic [TAG_W-1:0] c_label [N];

	// slot index: first valid cell with last >= a
	logic [CW-1:0] slot_s1;
	logic [AW-1:0] s_first, s_last, p_last;
	logic [TAG_W-1:0] s_label, p_label;
	logic s_valid, p_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			low_q <= '0;
			high_q <= '1;
		end else begin
			phase_q <= phase_d;
			if (cfg_we) begin
				if (cfg_index == REG_LOW) low_q <= to_aw(cfg_data);
				else high_q <= to_aw(cfg_data);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_q <= mode;
			a_q <= to_aw(addr);
			size_q <= size;
			tag_q <= tag;
		end
	end

	assign in_ready = (phase_q == PH_IDLE) && (!out_valid || out_ready);

	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_IDLE: if (in_valid && in_ready) phase_d = PH_EXEC;
			PH_EXEC: phase_d = PH_IDLE;
			default: phase_d = PH_IDLE;
		endcase
	end

	// priority encode the compare vector, masked by count; no hit gives count
	always_comb begin
		slot_s1 = count_q;
		for (int k = N - 1; k >= 0; k--) begin
			if (ge[k] && (CW'(k) < count_q)) slot_s1 = CW'(k);
		end
	end

	logic [IW-1:0] si, pi;
	assign si = slot_s1[IW-1:0];
	assign pi = si - IW'(1);
	assign s_valid = slot_s1 < count_q;
	assign p_valid = slot_s1 != '0;
	assign s_first = c_first[si];
	assign s_last = c_last[si];
	assign s_label = c_label[si];
	assign p_last = c_last[pi];
	assign p_label = c_label[pi];

	// span check
	logic [AW:0] sum;
	logic [AW-1:0] e;
	logic span_ok;
	logic [XW-1:0] size_x;
	always_comb begin
		size_x = XW'(size_q);
		sum = {1'b0, a_q} + {1'b0, size_x[AW-1:0]} - (AW+1)'(1);
		e = sum[AW-1:0];
		span_ok = (size_q != '0) && !(e < a_q) && !(a_q < low_q) && !(e > high_q);
	end

	// decision
	status_t st;
	cmd_t cmd;
	logic [IW-1:0] wsel;
	logic [AW-1:0] w_first, w_last;
	logic [TAG_W-1:0] w_label;
	logic [IW-1:0] shift_at;
	logic [CW-1:0] count_d;
	logic full, pj, nj, lk;
	logic [IW-1:0] si1;
	assign si1 = si + IW'(1);

	always_comb begin
		st = ST_INVALID;
		cmd = CMD_HOLD;
		wsel = si;
		w_first = a_q;
		w_last = e;
		w_label = tag_q;
		shift_at = si;
		count_d = count_q;
		full = count_q >= CW'(N);
		pj = (tag_q == '0) && p_valid && (p_last + AW'(1) == a_q) && (p_label == '0);
		nj = (tag_q == '0) && s_valid && (e + AW'(1) == s_first) && (s_label == '0);
		lk = s_valid && (s_first <= a_q);
		case (mode_q)
			MODE_ALLOC: begin
				if (!span_ok || (s_valid && s_first <= e)) begin
					st = ST_INVALID;
				end else if (pj && nj) begin
					st = ST_OK;
					cmd = CMD_CLOSE;
					wsel = pi;
					w_first = c_first[pi];
					w_last = s_last;
					w_label = p_label;
					shift_at = si;
					count_d = count_q - CW'(1);
				end else if (pj) begin
					st = ST_OK;
					cmd = CMD_WRITE;
					wsel = pi;
					w_first = c_first[pi];
					w_last = e;
					w_label = p_label;
				end else if (nj) begin
					st = ST_OK;
					cmd = CMD_WRITE;
					w_first = a_q;
					w_last = s_last;
					w_label = s_label;
				end else if (full) begin
					st = ST_FULL;
				end else begin
					st = ST_OK;
					cmd = CMD_OPEN;
					count_d = count_q + CW'(1);
				end
			end
			MODE_FREE: begin
				if (!span_ok || !s_valid || s_first > a_q || e > s_last) begin
					st = ST_INVALID;
				end else if (s_label != '0) begin
					st = ST_BUSY;
				end else if (s_first == a_q && s_last == e) begin
					st = ST_OK;
					cmd = CMD_CLOSE;
					wsel = si;
					w_first = c_first[si1];
					w_last = c_last[si1];
					w_label = c_label[si1];
					shift_at = si;
					count_d = count_q - CW'(1);
				end else if (s_first == a_q) begin
					st = ST_OK;
					cmd = CMD_WRITE;
					w_first = e + AW'(1);
					w_last = s_last;
					w_label = s_label;
				end else if (s_last == e) begin
					st = ST_OK;
					cmd = CMD_WRITE;
					w_first = s_first;
					w_last = a_q - AW'(1);
					w_label = s_label;
				end else if (full) begin
					st = ST_FULL;
				end else begin
					// split: new upper piece opens at si+1, lower trims in place
					st = ST_OK;
					cmd = CMD_OPEN;
					wsel = si1;
					shift_at = si1;
					w_first = e + AW'(1);
					w_last = s_last;
					w_label = '0;
					count_d = count_q + CW'(1);
				end
			end
			MODE_LOOKUP: st = ST_OK;
			default: st = ST_INVALID;
		endcase
	end

	logic exec, split;
	assign exec = phase_q == PH_EXEC;
	assign split = (mode_q == MODE_FREE) && (cmd == CMD_OPEN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			if (exec) begin
				count_q <= count_d;
				out_valid <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			status <= st;
			found <= (mode_q == MODE_LOOKUP) && lk;
			range_start <= ((mode_q == MODE_LOOKUP) && lk) ? to_fw(s_first) : '0;
			range_end <= ((mode_q == MODE_LOOKUP) && lk) ? to_fw(s_last) : '0;
			range_tag <= ((mode_q == MODE_LOOKUP) && lk) ? s_label : '0;
		end
	end

	for (genvar k = 0; k < N; k++) begin : g_cell
		cmd_t k_cmd;
		logic k_sel;
		logic [AW-1:0] kf, kl;
		logic [TAG_W-1:0] kt;
		always_comb begin
			k_cmd = exec ? cmd : CMD_HOLD;
			k_sel = IW'(k) == wsel;
			kf = w_first;
			kl = w_last;
			kt = w_label;
			// split also trims the containing entry
			if (split && IW'(k) == si) begin
				k_cmd = CMD_WRITE;
				k_sel = 1'b1;
				kf = s_first;
				kl = a_q - AW'(1);
				kt = s_label;
			end
		end
		sram_cell #(.AW(AW)) u_cell (
			.clk(clk), .arst_n(arst_n), .key(a_q), .ge(ge[k]),
			.first(c_first[k]), .last(c_last[k]), .label(c_label[k]),
			.cmd(k_cmd), .sel(k_sel),
			.upper(IW'(k) > shift_at), .lower(IW'(k) >= shift_at),
			.w_first(kf), .w_last(kl), .w_label(kt),
			.l_first(c_first[(k + N - 1) % N]), .l_last(c_last[(k + N - 1) % N]),
			.l_label(c_label[(k + N - 1) % N]),
			.r_first(c_first[(k + 1) % N]), .r_last(c_last[(k + 1) % N]),
			.r_label(c_label[(k + 1) % N])
		);
	end
endmodule
`default_nettype wire

// ===== rtl/sram_cell.sv =====
`default_nettype none
// One table slot. Compares against the broadcast key and takes part in a
// shift when the table opens or closes a slot.
module sram_cell import sram_pkg::*; #(
	parameter int AW = ADDR_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [AW-1:0]    key,
	output logic                  ge,
	output logic [AW-1:0]         first,
	output logic [AW-1:0]         last,
	output logic [TAG_W-1:0]      label,
	input  wire cmd_t             cmd,
	input  wire logic             sel,
	input  wire logic             upper,
	input  wire logic             lower,
	input  wire logic [AW-1:0]    w_first,
	input  wire logic [AW-1:0]    w_last,
	input  wire logic [TAG_W-1:0] w_label,
	input  wire logic [AW-1:0]    l_first,
	input  wire logic [AW-1:0]    l_last,
	input  wire logic [TAG_W-1:0] l_label,
	input  wire logic [AW-1:0]    r_first,
	input  wire logic [AW-1:0]    r_last,
	input  wire logic [TAG_W-1:0] r_label
);
	logic [AW-1:0] first_q, last_q;
	logic [TAG_W-1:0] label_q;

	assign first = first_q;
	assign last = last_q;
	assign label = label_q;
	assign ge = last_q >= key;

	always_ff @(posedge clk) begin
		case (cmd)
			CMD_WRITE: begin
				if (sel) begin
					first_q <= w_first;
					last_q <= w_last;
					label_q <= w_label;
				end
			end
			CMD_OPEN: begin
				// take left neighbor above the open point
				if (sel) begin
					first_q <= w_first;
					last_q <= w_last;
					label_q <= w_label;
				end else if (upper) begin
					first_q <= l_first;
					last_q <= l_last;
					label_q <= l_label;
				end
			end
			CMD_CLOSE: begin
				if (sel) begin
					first_q <= w_first;
					last_q <= w_last;
					label_q <= w_label;
				end else if (lower) begin
					first_q <= r_first;
					last_q <= r_last;
					label_q <= r_label;
				end
			end
			default: begin
			end
		endcase
	end
	logic unused;
	assign unused = arst_n;
endmodule
`default_nettype wire
